// File: design/crse_pkg.sv
// shared types, constants and the horner step function of the spline evaluator
package crse_pkg;

   localparam int MAX_POINTS = 16;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int CNT_MIN    = 4;
   localparam int COORD_W    = 32;
   localparam int NUM_COORDS = 3;
   localparam int T_W        = 17;
   localparam int FRAC_W     = 16;
   localparam int D_W        = COORD_W + 1;
   localparam int D1_W       = COORD_W + 2;
   localparam int AB_W       = COORD_W + 6;
   localparam int ACC_W      = COORD_W + 8;
   localparam int PROD_W     = ACC_W + T_W + 1;
   localparam int NUM_STAGES = 6;
   localparam int NUM_TAPS   = 4;

   localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

   localparam int TAP_PM1 = 0;
   localparam int TAP_P0  = 1;
   localparam int TAP_P1  = 2;
   localparam int TAP_P2  = 3;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = COORD_W * NUM_COORDS;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_POINT_COUNT = '0;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_EVAL  = 1'b1
   } crse_req_kind_type;

   typedef logic signed [COORD_W-1:0] crse_coord_type;
   typedef crse_coord_type [NUM_COORDS-1:0] crse_point_type;

   typedef struct packed {
      logic [6:0]             pad;
      logic [T_W-1:0]         t_frac;
      logic [PTR_W-1:0]       segment_start;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_x;
      logic [PTR_W-1:0]       point_index;
   } crse_req_data_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } crse_load_type;

   // floor((x * t + half) / 2^16)
   function automatic logic signed [ACC_W-1:0] hstep(input logic signed [ACC_W-1:0] x,
                                                     input logic [T_W-1:0] t);
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] rnd;
      prod = PROD_W'(x) * PROD_W'(signed'({1'b0, t}));
      rnd  = (prod + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
      return rnd[ACC_W-1:0];
   endfunction

endpackage

// File: design/crse_point_ram.sv
// control point table copy with one write port and one registered read port
module crse_point_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [crse_pkg::PTR_W-1:0]       wr_addr,
   input  crse_pkg::crse_point_type         wr_data,
   input  logic                             rd_en,
   input  logic [crse_pkg::PTR_W-1:0]       rd_addr,
   output crse_pkg::crse_point_type         rd_data
);
   import crse_pkg::*;

   crse_point_type mem_ff [MAX_POINTS];
   crse_point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/crse_csr.sv
// configuration register block holding the point count
module crse_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crse_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crse_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [crse_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [crse_pkg::PTR_W-1:0]        last_seg
);
   import crse_pkg::*;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       count_clamped;
   logic [CSR_ADDR_W-3:0]  reg_index;
   logic                   wr_hit;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_index == REG_POINT_COUNT);
   assign count_in   = csr_pwdata[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(CNT_MIN);
      end else if (wr_hit) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (count_ff < CNT_W'(CNT_MIN)) begin
         count_clamped = CNT_W'(CNT_MIN);
      end else if (count_ff > CNT_W'(MAX_POINTS)) begin
         count_clamped = CNT_W'(MAX_POINTS);
      end else begin
         count_clamped = count_ff;
      end
   end

   assign last_seg   = PTR_W'(count_clamped - CNT_W'(2));
   assign csr_prdata = (reg_index == REG_POINT_COUNT) ? CSR_DATA_W'(count_ff) : '0;

endmodule

// File: design/crse_coord_path.sv
// pipelined hermite evaluation of one coordinate, stages two to six
module crse_coord_path (
   input  logic                                  clock,
   input  crse_pkg::crse_load_type               ld,
   input  logic signed [crse_pkg::COORD_W-1:0]   pm1,
   input  logic signed [crse_pkg::COORD_W-1:0]   p0,
   input  logic signed [crse_pkg::COORD_W-1:0]   p1,
   input  logic signed [crse_pkg::COORD_W-1:0]   p2,
   input  logic [crse_pkg::T_W-1:0]              t,
   input  logic                                  direct,
   input  logic                                  last,
   output logic signed [crse_pkg::COORD_W-1:0]   pos,
   output logic                                  clip
);
   import crse_pkg::*;

   logic signed [D_W-1:0]     d0_2_ff, dd_2_ff;
   logic signed [D1_W-1:0]    d1_2_ff;
   logic signed [COORD_W-1:0] p0_2_ff, p0_3_ff, p0_4_ff, p0_5_ff, p0_6_ff;
   logic [T_W-1:0]            t_2_ff, t_3_ff, t_4_ff, t_5_ff;
   logic                      dir_2_ff, dir_3_ff, dir_4_ff, dir_5_ff, dir_6_ff;
   logic signed [AB_W-1:0]    a_3_ff, b_3_ff;
   logic signed [D_W-1:0]     d0_3_ff, d0_4_ff;
   logic signed [ACC_W-1:0]   acc_4_ff, acc_5_ff, acc_6_ff;
   logic signed [ACC_W-1:0]   half;
   logic [ACC_W-COORD_W:0]    top_bits;
   logic                      over;

   always_ff @(posedge clock) begin
      if (ld.s2) begin
         d0_2_ff  <= D_W'(p1) - D_W'(pm1);
         dd_2_ff  <= D_W'(p1) - D_W'(p0);
         d1_2_ff  <= last ? (D1_W'(p1) - D1_W'(p0)) <<< 1 : D1_W'(p2) - D1_W'(p0);
         p0_2_ff  <= p0;
         t_2_ff   <= t;
         dir_2_ff <= direct;
      end
      if (ld.s3) begin
         a_3_ff   <= AB_W'(d0_2_ff) + AB_W'(d1_2_ff) - (AB_W'(dd_2_ff) <<< 2);
         b_3_ff   <= (AB_W'(dd_2_ff) <<< 2) + (AB_W'(dd_2_ff) <<< 1)
                     - (AB_W'(d0_2_ff) <<< 1) - AB_W'(d1_2_ff);
         d0_3_ff  <= d0_2_ff;
         p0_3_ff  <= p0_2_ff;
         t_3_ff   <= t_2_ff;
         dir_3_ff <= dir_2_ff;
      end
      if (ld.s4) begin
         acc_4_ff <= hstep(ACC_W'(a_3_ff), t_3_ff) + ACC_W'(b_3_ff);
         d0_4_ff  <= d0_3_ff;
         p0_4_ff  <= p0_3_ff;
         t_4_ff   <= t_3_ff;
         dir_4_ff <= dir_3_ff;
      end
      if (ld.s5) begin
         acc_5_ff <= hstep(acc_4_ff, t_4_ff) + ACC_W'(d0_4_ff);
         p0_5_ff  <= p0_4_ff;
         t_5_ff   <= t_4_ff;
         dir_5_ff <= dir_4_ff;
      end
      if (ld.s6) begin
         acc_6_ff <= hstep(acc_5_ff, t_5_ff) + (ACC_W'(p0_5_ff) <<< 1);
         p0_6_ff  <= p0_5_ff;
         dir_6_ff <= dir_5_ff;
      end
   end

   always_comb begin
      half     = (acc_6_ff + ACC_W'(1)) >>> 1;
      top_bits = half[ACC_W-1:COORD_W-1];
      over     = !((&top_bits) || !(|top_bits));
      if (dir_6_ff) begin
         pos = p0_6_ff;
      end else if (over) begin
         pos = {half[ACC_W-1], {(COORD_W-1){~half[ACC_W-1]}}};
      end else begin
         pos = half[COORD_W-1:0];
      end
      clip = !dir_6_ff && over;
   end

endmodule

// File: design/catmull_rom_spline_eval_top.sv
// catmull-rom spline evaluator top level: point table, pipeline control and output register
// Takes one item per clock cycle when the result side keeps up. A write item stores one
// control point in the table at its accept edge and gives no result; an evaluate item
// passes through the table read (four copies of the table, one per neighbor point), the
// tangent and then the coefficient arithmetic, the Horner steps with one 40x18 multiply
// each, and the output register with saturation. A stall on the result side holds every
// stage that holds an item while empty stages still fill, so new items go in until all
// stages are full. Points must be written before a segment that uses them is evaluated.
module catmull_rom_spline_eval_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_index, coord_x, coord_y, coord_z, segment_start, t_frac, zero fill
   input  logic [crse_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pos_x, pos_y, pos_z
   output logic [crse_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // clipped
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crse_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crse_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [crse_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import crse_pkg::*;

   crse_req_data_type       req_data;
   crse_req_kind_type       req_kind;
   logic                    req_acc;
   logic [PTR_W-1:0]        last_seg;
   logic [PTR_W-1:0]        seg;
   logic                    past_end;
   logic                    before_start;
   logic [PTR_W-1:0]        rd_addr [NUM_TAPS];
   crse_point_type          rd_data [NUM_TAPS];
   crse_point_type          wr_point;
   logic                    wr_en;
   logic [T_W-1:0]          t_clamped;

   logic [NUM_STAGES:1]     vld_ff;
   logic [NUM_STAGES+1:1]   rdy;
   logic                    rsp_vld_ff;
   crse_point_type          rsp_pos_ff;
   logic                    rsp_clip_ff;
   logic [T_W-1:0]          s1_t_ff;
   logic                    s1_direct_ff;
   logic                    s1_last_ff;
   crse_load_type           ld;
   crse_point_type          pos;
   logic [NUM_COORDS-1:0]   clip;

   assign req_data   = crse_req_data_type'(req_tdata);
   assign req_kind   = crse_req_kind_type'(req_tuser[0]);
   assign req_tready = rdy[1];
   assign req_acc    = req_tvalid && req_tready;

   crse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .last_seg    (last_seg)
   );

   // segment clamping, neighbor addresses and t clamping
   always_comb begin
      seg          = req_data.segment_start;
      past_end     = seg > last_seg;
      before_start = seg == '0;
      rd_addr[TAP_PM1] = seg - PTR_W'(1);
      rd_addr[TAP_P1]  = seg + PTR_W'(1);
      rd_addr[TAP_P2]  = seg + PTR_W'(2);
      if (past_end) begin
         rd_addr[TAP_P0] = last_seg;
      end else if (before_start) begin
         rd_addr[TAP_P0] = PTR_W'(1);
      end else begin
         rd_addr[TAP_P0] = seg;
      end
      t_clamped = (req_data.t_frac > T_ONE) ? T_ONE : req_data.t_frac;
   end

   assign wr_en    = req_acc && (req_kind == REQ_WRITE);
   assign wr_point = {req_data.coord_z, req_data.coord_y, req_data.coord_x};

   for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
      crse_point_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (req_data.point_index),
         .wr_data (wr_point),
         .rd_en   (rdy[1]),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_t_ff      <= t_clamped;
         s1_direct_ff <= past_end || before_start;
         s1_last_ff   <= seg == last_seg;
      end
   end

   always_comb begin
      rdy[NUM_STAGES+1] = !rsp_vld_ff || rsp_tready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign ld.s2 = rdy[2];
   assign ld.s3 = rdy[3];
   assign ld.s4 = rdy[4];
   assign ld.s5 = rdy[5];
   assign ld.s6 = rdy[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rdy[1]) begin
            vld_ff[1] <= req_tvalid && (req_kind == REQ_EVAL);
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (rdy[NUM_STAGES+1]) begin
            rsp_vld_ff <= vld_ff[NUM_STAGES];
         end
      end
   end

   for (genvar c = 0; c < NUM_COORDS; c++) begin : g_coord
      crse_coord_path u_path (
         .clock  (clock),
         .ld     (ld),
         .pm1    (signed'(rd_data[TAP_PM1][c])),
         .p0     (signed'(rd_data[TAP_P0][c])),
         .p1     (signed'(rd_data[TAP_P1][c])),
         .p2     (signed'(rd_data[TAP_P2][c])),
         .t      (s1_t_ff),
         .direct (s1_direct_ff),
         .last   (s1_last_ff),
         .pos    (pos[c]),
         .clip   (clip[c])
      );
   end

   always_ff @(posedge clock) begin
      if (rdy[NUM_STAGES+1]) begin
         rsp_pos_ff  <= pos;
         rsp_clip_ff <= |clip;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_pos_ff;
   assign rsp_tuser[0] = rsp_clip_ff;

   a_write_no_item: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_kind == REQ_WRITE) |=> !vld_ff[1])
      else $error("write item entered the evaluation pipeline");

   a_eval_enters: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_kind == REQ_EVAL) |=> vld_ff[1])
      else $error("evaluate item lost at entry");

   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_STAGES] && !rdy[NUM_STAGES+1] |=> vld_ff[NUM_STAGES])
      else $error("item dropped from last stage during stall");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && rsp_vld_ff && !rsp_tready |-> !req_tready)
      else $error("input ready while pipeline full and stalled");

endmodule

// File: tb/catmull_rom_spline_eval_top_tb.sv
// stream testbench for the spline evaluator: directed table, random items, predictor check
`timescale 1ns / 100ps

module catmull_rom_spline_eval_top_tb;
   import crse_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RAND_ITEMS    = 1250;
   localparam int NUM_PHASES    = 9;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 120;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_DIRECTED  = 21;

   localparam crse_coord_type MAXV = 32'sh7FFF_FFFF;
   localparam crse_coord_type MINV = 32'sh8000_0000;

   localparam logic [CNT_W-1:0] COUNT_SETTINGS [NUM_PHASES] =
      '{5'd16, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16, 5'd5, 5'd13, 5'd4};

   typedef struct packed {
      logic           clip;
      crse_point_type pos;
   } curve_point_type;

   typedef struct packed {
      crse_req_kind_type kind;
      logic [PTR_W-1:0]  slot;
      crse_coord_type    x;
      crse_coord_type    y;
      crse_coord_type    z;
      logic [PTR_W-1:0]  seg;
      logic [T_W-1:0]    t;
      logic              typed;
      curve_point_type   want;
   } stim_row_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata    = '0;
   logic [0:0]            req_tuser    = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   crse_coord_type     point_store [MAX_POINTS][NUM_COORDS];
   logic [CNT_W-1:0]   point_count_cfg  = 5'd4;
   curve_point_type    pending_points [$];
   int                 error_count      = 0;
   int                 cycle_count      = 0;
   int                 tx_idle_pct      = 36;
   int                 rx_idle_pct      = 55;
   int                 hold_left        = 0;
   logic               pressure_pending = 1'b0;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{REQ_WRITE, 4'd0, MINV, MAXV, 32'sd0, 4'd0, 17'd0, 1'b0, '0},
      '{REQ_WRITE, 4'd1, MAXV, MINV, 32'sh1234_5678, 4'd0, 17'd0, 1'b0, '0},
      '{REQ_WRITE, 4'd2, MAXV, MINV, 32'shFFFF_0000, 4'd0, 17'd0, 1'b0, '0},
      '{REQ_WRITE, 4'd3, MINV, MAXV, MAXV, 4'd0, 17'd0, 1'b0, '0},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd0, 1'b1,
        {1'b0, 32'h1234_5678, MINV, MAXV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd65536, 1'b1,
        {1'b0, 32'hFFFF_0000, MINV, MAXV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd32768, 1'b0, '0},
      // before the first segment
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd0, 17'd12345, 1'b1,
        {1'b0, 32'h1234_5678, MINV, MAXV}},
      // past the last segment
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd15, 17'd0, 1'b1,
        {1'b0, 32'hFFFF_0000, MINV, MAXV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd3, 17'd32768, 1'b1,
        {1'b0, 32'hFFFF_0000, MINV, MAXV}},
      // last segment, one-sided end tangent
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd2, 17'd65536, 1'b1,
        {1'b0, MAXV, MAXV, MINV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd2, 17'd16384, 1'b0, '0},
      // t above one
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'h1FFFF, 1'b1,
        {1'b0, 32'hFFFF_0000, MINV, MAXV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd65537, 1'b1,
        {1'b0, 32'hFFFF_0000, MINV, MAXV}},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd1, 1'b0, '0},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd2, 17'd65535, 1'b0, '0},
      '{REQ_WRITE, 4'd1, 32'sh0001_0000, 32'shFFFF_0000, 32'sd0, 4'd0, 17'd0, 1'b0, '0},
      '{REQ_WRITE, 4'd15, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_FFFF, 4'd0, 17'd0,
        1'b0, '0},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd1, 17'd32768, 1'b0, '0},
      '{REQ_EVAL, 4'd0, 32'sd0, 32'sd0, 32'sd0, 4'd0, 17'd0, 1'b1,
        {1'b0, 32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000}},
      '{REQ_WRITE, 4'd14, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, 4'd15, 17'h1FFFF,
        1'b0, '0}
   };

   catmull_rom_spline_eval_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int last_segment();
      int cnt;
      cnt = point_count_cfg;
      if (cnt < CNT_MIN) cnt = CNT_MIN;
      if (cnt > MAX_POINTS) cnt = MAX_POINTS;
      return cnt - 2;
   endfunction

   function automatic longint horner_round(input longint x, input longint t);
      return (x * t + 32768) >>> FRAC_W;
   endfunction

   function automatic curve_point_type predict_curve_point(input logic [PTR_W-1:0] seg,
                                                           input logic [T_W-1:0] t_raw);
      curve_point_type r;
      int n;
      int s;
      int c;
      longint t, p0, p1, d0, d1, a, b, acc;
      r = '0;
      n = last_segment();
      s = seg;
      t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
      for (c = 0; c < NUM_COORDS; c++) begin
         if (s > n) begin
            r.pos[c] = point_store[n][c];
         end else if (s < 1) begin
            r.pos[c] = point_store[1][c];
         end else begin
            p0  = point_store[s][c];
            p1  = point_store[s + 1][c];
            d0  = p1 - point_store[s - 1][c];
            d1  = (s < n) ? point_store[s + 2][c] - p0 : 2 * (p1 - p0);
            a   = 4 * p0 - 4 * p1 + d0 + d1;
            b   = -6 * p0 + 6 * p1 - 2 * d0 - d1;
            acc = horner_round(a, t) + b;
            acc = horner_round(acc, t) + d0;
            acc = horner_round(acc, t) + 2 * p0;
            acc = (acc + 1) >>> 1;
            if (acc > longint'(MAXV)) begin
               acc    = MAXV;
               r.clip = 1'b1;
            end else if (acc < longint'(MINV)) begin
               acc    = MINV;
               r.clip = 1'b1;
            end
            r.pos[c] = acc[COORD_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic crse_coord_type rand_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return MAXV;
         1: return MINV;
         2: return 32'sd0;
         3, 4, 5: return {{12{r[19]}}, r[19:0]};
         default: return r;
      endcase
   endfunction

   task automatic send_item(input crse_req_kind_type kind, input crse_req_data_type d,
                            input logic typed, input curve_point_type want);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_WRITE) begin
         point_store[d.point_index] = '{d.coord_x, d.coord_y, d.coord_z};
      end else begin
         pending_points.push_back(typed ? want
                                        : predict_curve_point(d.segment_start, d.t_frac));
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_count(input logic [CNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({REG_POINT_COUNT, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      point_count_cfg = value;
   endtask

   // receiver side, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (pressure_pending) begin
         hold_left        <= HOLD_CYCLES;
         pressure_pending <= 1'b0;
         rsp_tready       <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      curve_point_type got;
      curve_point_type want;
      int c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos  = rsp_tdata;
         got.clip = rsp_tuser[0];
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected item, expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            for (c = 0; c < NUM_COORDS; c++) begin
               if (got.pos[c] !== want.pos[c]) begin
                  $display("%0t: pos coord %0d expected %h actual %h",
                           $time, c, want.pos[c], got.pos[c]);
                  error_count++;
               end
            end
            if (got.clip !== want.clip) begin
               $display("%0t: clipped expected %b actual %b", $time, want.clip, got.clip);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("catmull_rom_spline_eval_top test failed");
         $finish;
      end
   end

   initial begin : stimulus
      crse_req_data_type d;
      crse_req_kind_type kind;
      int i;
      int k;
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         d               = '0;
         d.point_index   = directed_rows[i].slot;
         d.coord_x       = directed_rows[i].x;
         d.coord_y       = directed_rows[i].y;
         d.coord_z       = directed_rows[i].z;
         d.segment_start = directed_rows[i].seg;
         d.t_frac        = directed_rows[i].t;
         send_item(directed_rows[i].kind, d, directed_rows[i].typed, directed_rows[i].want);
      end

      k = 0;
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         csr_write_count(COUNT_SETTINGS[p]);
         // fill the rest of the table before any wider segment is read
         if (p == 0) begin
            for (i = 4; i < MAX_POINTS; i++) begin
               d             = '0;
               d.point_index = PTR_W'(i);
               d.coord_x     = rand_coord();
               d.coord_y     = rand_coord();
               d.coord_z     = rand_coord();
               send_item(REQ_WRITE, d, 1'b0, '0);
               k++;
            end
         end
         while (k < (p + 1) * RAND_ITEMS / NUM_PHASES) begin
            if (k == RAND_ITEMS / 3) begin
               tx_idle_pct <= 55;
               rx_idle_pct <= 36;
            end else if (k == 2 * RAND_ITEMS / 3) begin
               tx_idle_pct <= 0;
               rx_idle_pct <= 0;
            end
            if (k == 200 || k == 1000) pressure_pending <= 1'b1;
            kind            = ($urandom_range(3) == 0) ? REQ_WRITE : REQ_EVAL;
            d               = '0;
            d.point_index   = PTR_W'($urandom_range(MAX_POINTS - 1));
            d.coord_x       = rand_coord();
            d.coord_y       = rand_coord();
            d.coord_z       = rand_coord();
            d.segment_start = ($urandom_range(9) < 7)
                              ? PTR_W'($urandom_range(last_segment(), 1))
                              : PTR_W'($urandom_range(MAX_POINTS - 1));
            case ($urandom_range(9))
               0: d.t_frac = '0;
               1: d.t_frac = T_ONE;
               2: d.t_frac = T_W'($urandom_range(17'h1FFFF, 65537));
               3: d.t_frac = T_W'($urandom_range(15));
               default: d.t_frac = T_W'($urandom_range(65536));
            endcase
            send_item(kind, d, 1'b0, '0);
            k++;
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("catmull_rom_spline_eval_top test passed");
      end else begin
         $display("catmull_rom_spline_eval_top test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/crse_pkg.sv
design/crse_point_ram.sv
design/crse_csr.sv
design/crse_coord_path.sv
design/catmull_rom_spline_eval_top.sv
tb/catmull_rom_spline_eval_top_tb.sv
